### rtl/fpvl_pkg.sv
// Shared constants, types and helper functions for the 3D vector length block.
`default_nettype none

package fpvl_pkg;

  // Field and datapath widths.
  localparam int DATA_W      = 32;
  localparam int IN_TDATA_W  = 3 * DATA_W;
  localparam int OUT_TDATA_W = DATA_W;
  localparam int CLZ_W       = 6;
  localparam int SH_W        = 5;
  localparam int MAG_W       = 15;
  localparam int PROD_W      = 2 * MAG_W;
  localparam int FRAC_BITS   = 12;
  localparam int SQ_W        = 18;
  localparam int SUM_W       = 20;
  localparam int RAD_SHIFT   = 14;

  // Scaling thresholds and the rounding constant of the square rescale.
  localparam logic [CLZ_W-1:0]  SCALE_LIMIT = CLZ_W'(16);
  localparam logic [CLZ_W-1:0]  SCALE_BASE  = CLZ_W'(17);
  localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(2048);

  // Square root pipeline: two result bits per stage.
  localparam int ISQ_STEPS   = 2;
  localparam int ISQ_STAGES  = 9;
  localparam int RAD_W       = 2 * ISQ_STEPS * ISQ_STAGES;
  localparam int ROOT_W      = 17;
  localparam int REM_W       = 20;
  localparam int RAD_PAD     = RAD_W - SUM_W - RAD_SHIFT;

  // Request into the square root pipeline.
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [SH_W-1:0]  sh;
  } isq_req_t;

  // Response out of the square root pipeline.
  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SH_W-1:0]   sh;
  } isq_rsp_t;

  // Working state of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } isq_state_t;

  // Leading-zero count of a 32-bit word by binary search; 32 for zero.
  function automatic logic [CLZ_W-1:0] clz32(input logic [DATA_W-1:0] x);
    logic [CLZ_W-1:0]  n;
    logic [DATA_W-1:0] v;
    n = '0;
    v = x;
    if (v[31:16] == '0) begin
      n = n + CLZ_W'(16);
      v = {v[15:0], 16'b0};
    end
    if (v[31:24] == '0) begin
      n = n + CLZ_W'(8);
      v = {v[23:0], 8'b0};
    end
    if (v[31:28] == '0) begin
      n = n + CLZ_W'(4);
      v = {v[27:0], 4'b0};
    end
    if (v[31:30] == '0) begin
      n = n + CLZ_W'(2);
      v = {v[29:0], 2'b0};
    end
    if (v[31] == 1'b0) begin
      n = n + CLZ_W'(1);
      v = {v[30:0], 1'b0};
    end
    if (v[31] == 1'b0) begin
      n = n + CLZ_W'(1);
    end
    return n;
  endfunction

  // One restoring square root step: consumes two radicand bits, yields one root bit.
  function automatic isq_state_t isqrt_step(input isq_state_t s);
    isq_state_t       r;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    r.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/fpvl_isqrt.sv
// Pipelined integer square root, two result bits per stage, with per-stage flow control.
`default_nettype none

module fpvl_isqrt (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire fpvl_pkg::isq_req_t in_req,
  output logic                   out_valid,
  input  wire                    out_ready,
  output fpvl_pkg::isq_rsp_t     out_rsp
);

  localparam int N = fpvl_pkg::ISQ_STAGES;

  logic [N-1:0]                   vld;
  logic [N-1:0]                   en;
  fpvl_pkg::isq_state_t           st [N];
  logic [fpvl_pkg::SH_W-1:0]      sh [N];

  // A stage takes a new request when it is empty or its contents move on.
  assign en[N-1] = !vld[N-1] || out_ready;
  for (genvar k = 0; k < N - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_ready = en[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      prev_vld;
    fpvl_pkg::isq_state_t      prev_st;
    logic [fpvl_pkg::SH_W-1:0] prev_sh;
    fpvl_pkg::isq_state_t      nx;

    // Stage input comes from the port for the first stage, else from the stage before.
    if (k == 0) begin : g_first
      assign prev_vld     = in_valid;
      assign prev_st.rad  = in_req.rad;
      assign prev_st.rem  = '0;
      assign prev_st.root = '0;
      assign prev_sh      = in_req.sh;
    end else begin : g_rest
      assign prev_vld = vld[k-1];
      assign prev_st  = st[k-1];
      assign prev_sh  = sh[k-1];
    end

    // Root bits resolved in this stage.
    always_comb begin
      nx = prev_st;
      for (int i = 0; i < fpvl_pkg::ISQ_STEPS; i++) begin
        nx = fpvl_pkg::isqrt_step(nx);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st[k] <= nx;
        sh[k] <= prev_sh;
      end
    end
  end

  assign out_valid    = vld[N-1];
  assign out_rsp.root = st[N-1].root;
  assign out_rsp.sh   = sh[N-1];

endmodule

`default_nettype wire

### rtl/fixed_point_vector_length_3d_top.sv
// Top level of the 3D fixed-point vector length pipeline.
//
// Usage: one request on the s_axis channel carries a signed 20.12 vector
// (x, y, z) packed in s_axis_tdata; one result leaves on the m_axis channel
// with the 20.12 length, wrapped to 32 bits. Results come out in request order.
// An accepted request passes, in order, through five front-end stages
// (magnitude, leading-zero count, normalize, square, sum), nine square root
// stages resolving two root bits each, and the output register that rounds
// and scales back, before m_axis_tvalid rises.
// One request per cycle when nothing stalls; every stage has its own valid bit.
// When the receiver holds m_axis_tready low, the output register keeps its
// result and the stages behind it keep filling empty slots, so s_axis_tready
// only drops once every stage holds a request.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
`default_nettype none

module fixed_point_vector_length_3d_top (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata    // vec_length [31:0]
);

  localparam int DW  = fpvl_pkg::DATA_W;
  localparam int MW  = fpvl_pkg::MAG_W;
  localparam int SHW = fpvl_pkg::SH_W;
  localparam int ROOTW_P1 = fpvl_pkg::ROOT_W + 1;

  logic [4:0] vld;
  logic [4:0] en;

  logic                isq_in_ready;
  logic                isq_out_valid;
  logic                out_en;
  fpvl_pkg::isq_req_t  isq_req;
  fpvl_pkg::isq_rsp_t  isq_rsp;

  // Stage 0: magnitudes.
  logic [DW-1:0] mag0 [3];
  // Stage 1: shared scale.
  logic [DW-1:0] mag1 [3];
  logic [SHW-1:0] sh1;
  // Stage 2: normalized magnitudes.
  logic [MW-1:0] nrm2 [3];
  logic [SHW-1:0] sh2;
  // Stage 3: rescaled squares.
  logic [fpvl_pkg::SQ_W-1:0] sq3 [3];
  logic [SHW-1:0] sh3;
  // Stage 4: radicand.
  logic [fpvl_pkg::RAD_W-1:0] rad4;
  logic [SHW-1:0] sh4;

  logic [DW-1:0] mag_next [3];
  logic [fpvl_pkg::CLZ_W-1:0] lz;
  logic [SHW-1:0] sh_next;
  logic [MW-1:0] nrm_next [3];
  logic [fpvl_pkg::SQ_W-1:0] sq_next [3];
  logic [fpvl_pkg::SUM_W-1:0] sum_next;
  logic [ROOTW_P1-1:0] round_sum;
  logic [DW-1:0] length_next;

  // Flow control: each stage loads when empty or when it drains.
  assign en[4] = !vld[4] || isq_in_ready;
  assign en[3] = !vld[3] || en[4];
  assign en[2] = !vld[2] || en[3];
  assign en[1] = !vld[1] || en[2];
  assign en[0] = !vld[0] || en[1];
  assign s_axis_tready = en[0];
  assign out_en = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
      if (en[3]) vld[3] <= vld[2];
      if (en[4]) vld[4] <= vld[3];
    end
  end

  // Absolute values, taken as unsigned; the most negative value gives 2^31.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_next[i] = s_axis_tdata[i*DW +: DW];
      if (mag_next[i][DW-1]) begin
        mag_next[i] = DW'(0) - mag_next[i];
      end
    end
  end

  // The smallest leading-zero count is that of the OR of the three magnitudes.
  always_comb begin
    lz = fpvl_pkg::clz32(mag0[0] | mag0[1] | mag0[2]);
    if (lz <= fpvl_pkg::SCALE_LIMIT) begin
      sh_next = SHW'(fpvl_pkg::SCALE_BASE - lz);
    end else begin
      sh_next = '0;
    end
  end

  // After the shift every magnitude fits in 15 bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_next[i] = MW'(mag1[i] >> sh1);
    end
  end

  // Squares with a rounded 12-bit rescale.
  always_comb begin
    logic [fpvl_pkg::PROD_W-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod = fpvl_pkg::PROD_W'(nrm2[i]) * fpvl_pkg::PROD_W'(nrm2[i])
           + fpvl_pkg::ROUND_HALF;
      sq_next[i] = prod[fpvl_pkg::FRAC_BITS +: fpvl_pkg::SQ_W];
    end
  end

  assign sum_next = fpvl_pkg::SUM_W'(sq3[0]) + fpvl_pkg::SUM_W'(sq3[1])
                  + fpvl_pkg::SUM_W'(sq3[2]);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag0 <= mag_next;
    end
    if (en[1]) begin
      mag1 <= mag0;
      sh1  <= sh_next;
    end
    if (en[2]) begin
      nrm2 <= nrm_next;
      sh2  <= sh1;
    end
    if (en[3]) begin
      sq3 <= sq_next;
      sh3 <= sh2;
    end
    if (en[4]) begin
      rad4 <= {{fpvl_pkg::RAD_PAD{1'b0}}, sum_next, {fpvl_pkg::RAD_SHIFT{1'b0}}};
      sh4  <= sh3;
    end
  end

  assign isq_req.rad = rad4;
  assign isq_req.sh  = sh4;

  fpvl_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[4]),
    .in_ready  (isq_in_ready),
    .in_req    (isq_req),
    .out_valid (isq_out_valid),
    .out_ready (out_en),
    .out_rsp   (isq_rsp)
  );

  // Round the 4.13 root to 5.12, then undo the scaling with a wrapping shift to 20.12.
  assign round_sum   = ROOTW_P1'(isq_rsp.root) + ROOTW_P1'(1);
  assign length_next = DW'(round_sum[ROOTW_P1-1:1]) << isq_rsp.sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= isq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      m_axis_tdata <= length_next;
    end
  end

  // A scaled vector always has its largest normalized magnitude using all 15 bits.
  a_norm_full: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && sh2 != '0) |-> ((nrm2[0] | nrm2[1] | nrm2[2]) >> (MW - 1)) == MW'(1))
    else $error("normalized magnitudes do not fill 15 bits");

  // An empty first stage must always take a request.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[0] |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  // An accepted request occupies the first stage in the next cycle.
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> vld[0])
    else $error("accepted request was lost");

endmodule

`default_nettype wire

### tb/sv/fixed_point_vector_length_3d_top_tb.sv
// Self-checking stream testbench for the 3D fixed-point vector length pipeline.
module fixed_point_vector_length_3d_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = fpvl_pkg::DATA_W;

  // Arithmetic constants of the length computation.
  localparam longint unsigned SQ_ROUND = 2048;
  localparam int FRAC = 12;
  localparam int SHIFT_BASE = 17;
  localparam int SHIFT_LIMIT = 16;
  localparam int ROOT_PREP = 14;

  // Run shaping.
  localparam int RANDOM_VECTORS = 1330;
  localparam int SETTLE_AT = 700;
  localparam int QUIET_TAIL = 150;
  localparam int STALL_AT = 400;
  localparam int LONG_STALL = 80;
  localparam int DRAIN_WAIT = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] z;
    bit           settle_first;
  } vec_req_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [3*W-1:0] s_axis_tdata = '0;   // vec_x, vec_y, vec_z from the lowest bit up
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [W-1:0]  m_axis_tdata;        // vec_length

  vec_req_t     vectors_to_send[$];
  logic [W-1:0] lengths_due[$];
  int           sent_count = 0;
  int           total_vectors = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           send_gap = 0;
  int           hold_left = 0;
  bit           long_hold_done = 1'b0;
  logic         in_fire = 1'b0;
  logic         out_fire;

  fixed_point_vector_length_3d_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk = ~clk;

  // Absolute value taken as an unsigned 32-bit magnitude.
  function automatic logic [W-1:0] abs_mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // Leading zeros of a word; the full width for zero.
  function automatic int lead_zeros(input logic [W-1:0] v);
    int n;
    int i;
    n = W;
    for (i = 0; i < W; i++) begin
      if (v[i]) n = W - 1 - i;
    end
    return n;
  endfunction

  // Integer square root, rounded down, built one bit at a time.
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    int i;
    r = 0;
    for (i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Square of a scaled magnitude with a rounded rescale back to 20.12.
  function automatic longint unsigned rescaled_square(input logic [W-1:0] a);
    longint unsigned w;
    w = a;
    return (w * w + SQ_ROUND) >> FRAC;
  endfunction

  // Expected vector length for one request.
  function automatic logic [W-1:0] predict_length(input logic [W-1:0] x, y, z);
    logic [W-1:0]    ax;
    logic [W-1:0]    ay;
    logic [W-1:0]    az;
    int              lz;
    int              sh;
    longint unsigned total;
    longint unsigned root;
    ax = abs_mag(x);
    ay = abs_mag(y);
    az = abs_mag(z);
    lz = lead_zeros(ax);
    if (lead_zeros(ay) < lz) lz = lead_zeros(ay);
    if (lead_zeros(az) < lz) lz = lead_zeros(az);
    sh = 0;
    // Scale all components down so the largest fits in 15 bits.
    if (lz <= SHIFT_LIMIT) begin
      sh = SHIFT_BASE - lz;
      ax = ax >> sh;
      ay = ay >> sh;
      az = az >> sh;
    end
    total = rescaled_square(ax) + rescaled_square(ay) + rescaled_square(az);
    root = (total == 0) ? 64'd0 : ((floor_sqrt(total << ROOT_PREP) + 1) >> 1);
    root = root << sh;
    return root[W-1:0];
  endfunction

  // One component with about span significant bits and a random sign.
  function automatic logic [W-1:0] random_component(input int span);
    logic [W-1:0] v;
    v = $urandom;
    if (span < W) v = v & ((32'd1 << span) - 1);
    if ($urandom_range(1, 0) == 1) v = ~v + 1'b1;
    return v;
  endfunction

  // Corner values that stress the magnitude and scaling logic.
  function automatic logic [W-1:0] corner_component();
    case ($urandom_range(7, 0))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 32'hFFFF_FFFF;
      4: return 32'h0000_7FFF;
      5: return 32'h0000_8000;
      6: return 32'hFFFF_8000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic queue_vector(input logic [W-1:0] x, y, z, input bit settle);
    vec_req_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.settle_first = settle;
    vectors_to_send.push_back(r);
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int i;
    int span;
    int pick;
    // Directed corners: zero, unit, extremes, scaling threshold, wrap-around.
    queue_vector(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    queue_vector(32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_vector(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_vector(32'h0000_7FFF, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_vector(32'hFFFF_8001, 32'h0000_7FFF, 32'hFFFF_8001, 1'b0);
    queue_vector(32'h0000_0000, 32'h0000_FFFF, 32'h0001_0000, 1'b0);
    queue_vector(32'h0000_3000, 32'h0000_4000, 32'h0000_0000, 1'b0);
    queue_vector(32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_E000, 1'b0);
    queue_vector(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
    queue_vector(32'h4000_0000, 32'hC000_0000, 32'h2000_0000, 1'b0);
    queue_vector(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
    queue_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0);

    // Random vectors over many scales so both the scaled and unscaled paths run.
    for (i = 0; i < RANDOM_VECTORS; i++) begin
      pick = $urandom_range(9, 0);
      if (pick <= 2) begin
        queue_vector($urandom, $urandom, $urandom, i == 0 || i == SETTLE_AT);
      end else if (pick <= 6) begin
        span = $urandom_range(W, 0);
        queue_vector(random_component(span), random_component(span),
                     random_component($urandom_range(span, 0)), i == 0 || i == SETTLE_AT);
      end else if (pick == 7) begin
        span = $urandom_range(18, 14);
        queue_vector(random_component(span), random_component(span),
                     random_component(span), i == 0 || i == SETTLE_AT);
      end else if (pick == 8) begin
        queue_vector(corner_component(), corner_component(), corner_component(),
                     i == 0 || i == SETTLE_AT);
      end else begin
        span = $urandom_range(W, 1);
        queue_vector(32'h0, random_component(span), ($urandom_range(1, 0) == 1) ?
                     random_component(span) : 32'h0, i == 0 || i == SETTLE_AT);
      end
    end
    total_vectors = vectors_to_send.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (vectors_to_send.size() != 0 || s_axis_tvalid || lengths_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && lengths_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sender: offers requests at the falling edge, with random gaps.
  always @(negedge clk) begin
    logic           nv;
    logic [3*W-1:0] nd;
    vec_req_t       r;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (rst) begin
      nv = 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (vectors_to_send.size() != 0) begin
        if (vectors_to_send[0].settle_first && lengths_due.size() != 0) begin
          // Pause until every outstanding result has been returned.
        end else if (sent_count < total_vectors - QUIET_TAIL &&
                     (sent_count / 100) % 3 != 2 && $urandom_range(7, 0) == 0) begin
          send_gap = $urandom_range(2, 0);
        end else begin
          r = vectors_to_send.pop_front();
          nv = 1'b1;
          nd = {r.z, r.y, r.x};
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // Receiver: ready at the falling edge, with short bursts and one long hold-off.
  always @(negedge clk) begin
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      nr = 1'b0;
    end else if (!long_hold_done && sent_count >= STALL_AT) begin
      long_hold_done = 1'b1;
      hold_left = LONG_STALL - 1;
      nr = 1'b0;
    end else if (sent_count < total_vectors - QUIET_TAIL &&
                 (sent_count / 100) % 3 != 1 && $urandom_range(7, 0) == 0) begin
      hold_left = $urandom_range(2, 0);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    m_axis_tready <= nr;
  end

  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Monitor: records accepted requests and checks returned lengths in order.
  always @(posedge clk) begin
    logic [W-1:0] want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        lengths_due.push_back(predict_length(s_axis_tdata[W-1:0], s_axis_tdata[2*W-1:W],
                                             s_axis_tdata[3*W-1:2*W]));
        sent_count++;
      end
      if (out_fire) begin
        if (lengths_due.size() == 0) begin
          $display("%0t: unexpected vec_length, expected none, actual %h", $time,
                   m_axis_tdata);
          mismatches++;
        end else begin
          want = lengths_due.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: vec_length mismatch, expected %h, actual %h", $time, want,
                     m_axis_tdata);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither side has moved a request for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || out_fire) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d lengths still outstanding", $time, lengths_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
